>>> rtl/dn2cd_pkg.sv
`timescale 1ns / 1ps

package dn2cd_pkg;

  localparam logic signed [23:0] CountMin = -24'sd4371596;
  localparam logic signed [23:0] CountMax = 24'sd2932896;
  localparam logic signed [23:0] GregCut  = -24'sd79366;

  localparam logic [24:0] GregOffset = 25'd719468;
  localparam logic [24:0] JulOffset  = 25'd4371970;
  localparam logic [24:0] WdayOffset = 25'd4899997;

  localparam logic [13:0] RecipGreg = 14'd114;
  localparam logic [13:0] RecipJul  = 14'd11483;
  localparam logic [17:0] DaysEraGreg = 18'd146097;
  localparam logic [17:0] DaysEraJul  = 18'd1461;
  localparam logic [15:0] DaysCent    = 16'd36524;
  localparam logic [10:0] DaysQuad    = 11'd1461;
  localparam logic [8:0]  DaysYear    = 9'd365;
  localparam logic signed [15:0] JulYearBias = 16'sd10000;

  typedef struct packed {
    logic        greg;
    logic [11:0] era;
    logic [17:0] doe;
    logic [2:0]  wday;
  } dn2cd_era_t;

  typedef struct packed {
    logic        greg;
    logic [11:0] era;
    logic [8:0]  yoe;
    logic [8:0]  doy;
    logic [2:0]  wday;
  } dn2cd_yday_t;

  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/dn2cd_front.sv
`timescale 1ns / 1ps

module dn2cd_front import dn2cd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [23:0]       day_count_i,
  output logic              vld_o,
  input  logic              hold_i,
  output dn2cd_era_t        data_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic e1, e2, e3, e4;

  logic        greg1_q, greg2_q, greg3_q;
  logic [22:0] z1_q, z2_q, z3_q;
  logic [22:0] u1_q;
  logic [11:0] qa2_q, qa3_q;
  logic [22:0] pa3_q;
  logic [5:0]  ws2_q;
  logic [3:0]  ws3_q;
  dn2cd_era_t  s4_q;

  logic        greg1_d;
  logic [22:0] z1_d;
  logic [22:0] u1_d;
  logic [11:0] qa2_d;
  logic [5:0]  ws2_d;
  dn2cd_era_t  s4_d;

  assign e4 = !v4_q || !hold_i;
  assign e3 = !v3_q || e4;
  assign e2 = !v2_q || e3;
  assign e1 = !v1_q || e2;
  assign in_stall_o = !e1;

  always_comb begin
    logic signed [23:0] cnt;
    logic [24:0] ext;
    cnt = $signed(day_count_i);
    if (cnt < CountMin || cnt > CountMax) begin
      cnt = 24'sd0;
    end
    ext = {cnt[23], cnt};
    greg1_d = (cnt >= GregCut);
    if (greg1_d) begin
      z1_d = 23'(ext + GregOffset);
    end else begin
      z1_d = 23'(ext + JulOffset);
    end
    u1_d = 23'(ext + WdayOffset);
  end

  always_comb begin
    logic [35:0] prod;
    logic [23:0] up;
    prod = {13'd0, z1_q} * {22'd0, (greg1_q ? RecipGreg : RecipJul)};
    qa2_d = prod[35:24];
    up = {1'b0, u1_q};
    ws2_d = 6'd0;
    for (int i = 0; i < 8; i++) begin
      ws2_d = ws2_d + {3'd0, up[3*i +: 3]};
    end
  end

  always_comb begin
    logic [22:0] r;
    logic [17:0] dsel;
    logic [3:0]  v;
    dsel = greg3_q ? DaysEraGreg : DaysEraJul;
    r = z3_q - pa3_q;
    s4_d.greg = greg3_q;
    if (r >= {5'd0, dsel}) begin
      s4_d.era = qa3_q + 12'd1;
      s4_d.doe = 18'(r - {5'd0, dsel});
    end else begin
      s4_d.era = qa3_q;
      s4_d.doe = r[17:0];
    end
    v = ws3_q;
    if (v >= 4'd14) begin
      v = v - 4'd14;
    end else if (v >= 4'd7) begin
      v = v - 4'd7;
    end
    s4_d.wday = (v == 4'd0) ? 3'd7 : v[2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (e1) v1_q <= in_valid_i;
      if (e2) v2_q <= v1_q;
      if (e3) v3_q <= v2_q;
      if (e4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e1) begin
      greg1_q <= greg1_d;
      z1_q    <= z1_d;
      u1_q    <= u1_d;
    end
    if (e2) begin
      greg2_q <= greg1_q;
      z2_q    <= z1_q;
      qa2_q   <= qa2_d;
      ws2_q   <= ws2_d;
    end
    if (e3) begin
      greg3_q <= greg2_q;
      z3_q    <= z2_q;
      qa3_q   <= qa2_q;
      pa3_q   <= 23'({11'd0, qa2_q} * {5'd0, (greg2_q ? DaysEraGreg : DaysEraJul)});
      ws3_q   <= {1'b0, ws2_q[2:0]} + {1'b0, ws2_q[5:3]};
    end
    if (e4) begin
      s4_q <= s4_d;
    end
  end

  assign vld_o  = v4_q;
  assign data_o = s4_q;

endmodule

>>> rtl/dn2cd_split.sv
`timescale 1ns / 1ps

module dn2cd_split import dn2cd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  output logic        hold_o,
  input  dn2cd_era_t  data_i,
  output logic        vld_o,
  input  logic        hold_i,
  output dn2cd_yday_t data_o
);

  logic v5_q, v6_q, v7_q, v8_q, v9_q;
  logic e5, e6, e7, e8, e9;

  logic        greg5_q, greg6_q, greg7_q, greg8_q;
  logic [11:0] era5_q, era6_q, era7_q, era8_q;
  logic [2:0]  wd5_q, wd6_q, wd7_q, wd8_q;
  logic [1:0]  cent5_q, cent6_q, cent7_q, cent8_q;
  logic [15:0] dc5_q, dc6_q, dc7_q;
  logic [4:0]  qb6_q, qb7_q, quad8_q;
  logic [15:0] pb7_q;
  logic [10:0] dq8_q;
  dn2cd_yday_t s9_q;

  logic [1:0]  cent5_d;
  logic [15:0] dc5_d;
  logic [4:0]  quad8_d;
  logic [10:0] dq8_d;
  dn2cd_yday_t s9_d;

  assign e9 = !v9_q || !hold_i;
  assign e8 = !v8_q || e9;
  assign e7 = !v7_q || e8;
  assign e6 = !v6_q || e7;
  assign e5 = !v5_q || e6;
  assign hold_o = !e5;

  always_comb begin
    if (!data_i.greg) begin
      cent5_d = 2'd0;
      dc5_d   = data_i.doe[15:0];
    end else if (data_i.doe >= 18'd109572) begin
      cent5_d = 2'd3;
      dc5_d   = 16'(data_i.doe - 18'd109572);
    end else if (data_i.doe >= 18'd73048) begin
      cent5_d = 2'd2;
      dc5_d   = 16'(data_i.doe - 18'd73048);
    end else if (data_i.doe >= {2'd0, DaysCent}) begin
      cent5_d = 2'd1;
      dc5_d   = 16'(data_i.doe - {2'd0, DaysCent});
    end else begin
      cent5_d = 2'd0;
      dc5_d   = data_i.doe[15:0];
    end
  end

  always_comb begin
    logic [15:0] r;
    r = dc7_q - pb7_q;
    if (r >= {5'd0, DaysQuad}) begin
      quad8_d = qb7_q + 5'd1;
      dq8_d   = 11'(r - {5'd0, DaysQuad});
    end else begin
      quad8_d = qb7_q;
      dq8_d   = r[10:0];
    end
  end

  always_comb begin
    logic [1:0]  yr;
    logic [10:0] sub;
    if (dq8_q >= 11'd1095) begin
      yr = 2'd3;
      sub = 11'd1095;
    end else if (dq8_q >= 11'd730) begin
      yr = 2'd2;
      sub = 11'd730;
    end else if (dq8_q >= {2'd0, DaysYear}) begin
      yr = 2'd1;
      sub = {2'd0, DaysYear};
    end else begin
      yr = 2'd0;
      sub = 11'd0;
    end
    s9_d.greg = greg8_q;
    s9_d.era  = era8_q;
    s9_d.wday = wd8_q;
    s9_d.doy  = 9'(dq8_q - sub);
    s9_d.yoe  = 9'({7'd0, cent8_q} * 9'd100) + {2'd0, quad8_q, 2'd0} + {7'd0, yr};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      if (e5) v5_q <= vld_i;
      if (e6) v6_q <= v5_q;
      if (e7) v7_q <= v6_q;
      if (e8) v8_q <= v7_q;
      if (e9) v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e5) begin
      greg5_q <= data_i.greg;
      era5_q  <= data_i.era;
      wd5_q   <= data_i.wday;
      cent5_q <= cent5_d;
      dc5_q   <= dc5_d;
    end
    if (e6) begin
      greg6_q <= greg5_q;
      era6_q  <= era5_q;
      wd6_q   <= wd5_q;
      cent6_q <= cent5_q;
      dc6_q   <= dc5_q;
      qb6_q   <= 5'(({14'd0, dc5_q} * {16'd0, RecipJul}) >> 24);
    end
    if (e7) begin
      greg7_q <= greg6_q;
      era7_q  <= era6_q;
      wd7_q   <= wd6_q;
      cent7_q <= cent6_q;
      dc7_q   <= dc6_q;
      qb7_q   <= qb6_q;
      pb7_q   <= {11'd0, qb6_q} * {5'd0, DaysQuad};
    end
    if (e8) begin
      greg8_q <= greg7_q;
      era8_q  <= era7_q;
      wd8_q   <= wd7_q;
      cent8_q <= cent7_q;
      quad8_q <= quad8_d;
      dq8_q   <= dq8_d;
    end
    if (e9) begin
      s9_q <= s9_d;
    end
  end

  assign vld_o  = v9_q;
  assign data_o = s9_q;

endmodule

>>> rtl/dn2cd_month.sv
`timescale 1ns / 1ps

module dn2cd_month import dn2cd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  output logic               hold_o,
  input  dn2cd_yday_t        data_i,
  output logic               vld_o,
  input  logic               hold_i,
  output logic signed [14:0] year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_of_month_o,
  output logic [2:0]         weekday_o
);

  logic v10_q, v11_q;
  logic e10, e11;

  logic [3:0]         mp10_q;
  logic [8:0]         doy10_q;
  logic signed [15:0] yb10_q;
  logic [2:0]         wd10_q;

  logic [3:0]         mp10_d;
  logic signed [15:0] yb10_d;

  logic signed [14:0] year_q;
  logic [3:0]         month_q;
  logic [4:0]         dom_q;
  logic [2:0]         wd_q;

  assign e11 = !v11_q || !hold_i;
  assign e10 = !v10_q || e11;
  assign hold_o = !e10;

  always_comb begin
    logic [15:0] ebase;
    mp10_d = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (data_i.doy >= month_start(4'(i))) begin
        mp10_d = mp10_d + 4'd1;
      end
    end
    if (data_i.greg) begin
      ebase = 16'({4'd0, data_i.era} * 16'd400);
      yb10_d = $signed(ebase + {7'd0, data_i.yoe});
    end else begin
      ebase = {2'd0, data_i.era, 2'd0};
      yb10_d = $signed(ebase + {7'd0, data_i.yoe}) - JulYearBias;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else begin
      if (e10) v10_q <= vld_i;
      if (e11) v11_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e10) begin
      mp10_q  <= mp10_d;
      doy10_q <= data_i.doy;
      yb10_q  <= yb10_d;
      wd10_q  <= data_i.wday;
    end
    if (e11) begin
      month_q <= (mp10_q < 4'd10) ? mp10_q + 4'd3 : mp10_q - 4'd9;
      dom_q   <= 5'(doy10_q - month_start(mp10_q) + 9'd1);
      year_q  <= 15'(yb10_q + ((mp10_q >= 4'd10) ? 16'sd1 : 16'sd0));
      wd_q    <= wd10_q;
    end
  end

  assign vld_o          = v11_q;
  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = dom_q;
  assign weekday_o      = wd_q;

endmodule

>>> rtl/day_number_to_civil_date_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   day_count_i
// out      output     out_valid_o / out_stall_i year_o, month_o, day_of_month_o, weekday_o
//
// One item enters per cycle while in_stall_o is low. The result is offered once it
// has passed eleven register stages: era split, century, four-year
// and year split, then month lookup.
// Reset clears only the stage valid bits.
// A stalled output holds its stage; bubbles upstream still close up.

module day_number_to_civil_date_top import dn2cd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [23:0]        day_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_of_month_o,
  output logic [2:0]         weekday_o
);

  logic        fr_vld, fr_hold;
  dn2cd_era_t  fr_data;
  logic        sp_vld, sp_hold;
  dn2cd_yday_t sp_data;

  dn2cd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .day_count_i (day_count_i),
    .vld_o       (fr_vld),
    .hold_i      (fr_hold),
    .data_o      (fr_data)
  );

  dn2cd_split u_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (fr_vld),
    .hold_o (fr_hold),
    .data_i (fr_data),
    .vld_o  (sp_vld),
    .hold_i (sp_hold),
    .data_o (sp_data)
  );

  dn2cd_month u_month (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vld_i          (sp_vld),
    .hold_o         (sp_hold),
    .data_i         (sp_data),
    .vld_o          (out_valid_o),
    .hold_i         (out_stall_i),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .weekday_o      (weekday_o)
  );

`ifndef SYNTHESIS
  a_stall_only_on_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= 4'd1 && month_o <= 4'd12 && day_of_month_o != 5'd0))
    else $error("month or day out of range");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (weekday_o != 3'd0))
    else $error("weekday out of range");
`endif

endmodule

>>> tb/day_number_to_civil_date_checker.sv
`timescale 1ns / 1ps

module day_number_to_civil_date_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [23:0]        day_count_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [14:0] year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_of_month_i,
  input  logic [2:0]         weekday_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         mday;
    logic [2:0]         wday;
  } civil_date_t;

  civil_date_t pending_dates[$];

  function automatic bit is_leap(int y);
    if (y > 1752 && (y % 100) == 0) begin
      return (y % 400) == 0;
    end
    return (y % 4) == 0;
  endfunction

  function automatic int days_in_year(int y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic civil_date_t civil_date_of(logic [23:0] raw);
    int          cnt;
    int          d;
    int          y;
    int          m;
    int          mlen;
    int          w;
    civil_date_t r;
    cnt = int'(signed'(raw));
    if (cnt < -4371596 || cnt > 2932896) begin
      cnt = 0;
    end
    d = cnt;
    y = 1970;
    if (d >= 0) begin
      while (d >= days_in_year(y)) begin
        d -= days_in_year(y);
        y++;
      end
    end else begin
      if (d < -79366) begin
        d -= 11;
      end
      while (d < 0) begin
        y--;
        d += days_in_year(y);
      end
    end
    d += 1;
    m = 1;
    for (int i = 1; i <= 12; i++) begin
      case (i)
        2:           mlen = is_leap(y) ? 29 : 28;
        4, 6, 9, 11: mlen = 30;
        default:     mlen = 31;
      endcase
      if (d > mlen && i < 12) begin
        d -= mlen;
        m++;
      end else begin
        break;
      end
    end
    w = (cnt - 3) % 7;
    if (w <= 0) begin
      w += 7;
    end
    r.year  = y[14:0];
    r.month = m[3:0];
    r.mday  = d[4:0];
    r.wday  = w[2:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    checked_o = 0;
  end

  assign pending_o = pending_dates.size();

  always @(posedge clk_i) begin
    civil_date_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        pending_dates.push_back(civil_date_of(day_count_i));
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (pending_dates.size() == 0) begin
          report_mismatch("unexpected item, year", int'(year_i), 0);
        end else begin
          want = pending_dates.pop_front();
          if (year_i !== want.year) begin
            report_mismatch("year", int'(year_i), int'(want.year));
          end
          if (month_i !== want.month) begin
            report_mismatch("month", month_i, want.month);
          end
          if (day_of_month_i !== want.mday) begin
            report_mismatch("day_of_month", day_of_month_i, want.mday);
          end
          if (weekday_i !== want.wday) begin
            report_mismatch("weekday", weekday_i, want.wday);
          end
        end
      end
    end
  end

endmodule

>>> tb/tb_day_number_to_civil_date_top.sv
`timescale 1ns / 1ps

module tb_day_number_to_civil_date_top;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [23:0]        day_count_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [14:0] year_o;
  logic [3:0]         month_o;
  logic [4:0]         day_of_month_o;
  logic [2:0]         weekday_o;

  int fail_count;
  int pending;
  int checked;
  int sent = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  day_number_to_civil_date_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .day_count_i,
    .out_valid_o, .out_stall_i, .year_o, .month_o, .day_of_month_o, .weekday_o
  );

  day_number_to_civil_date_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .day_count_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .year_i(year_o), .month_i(month_o), .day_of_month_i(day_of_month_o),
    .weekday_i(weekday_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // The receiver changes its stall pattern whenever its phase counter wraps and serves long hold-offs.
  always @(posedge clk_i) begin
    int hold_left;
    int mode;
    int phase;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = 300;
      out_stall_i <= 1'b1;
    end else begin
      if (phase == 0) begin
        mode = $urandom_range(0, 2);
      end
      phase = (phase + 1) % 64;
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 5000) begin
      $display("watchdog expired with %0d items outstanding", pending);
      $display("tb_day_number_to_civil_date_top failed");
      $finish;
    end
  end

  task automatic send_count(logic [23:0] value);
    in_valid_i <= 1'b1;
    day_count_i <= value;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    sent++;
  endtask

  task automatic pause_sender(int cycles);
    in_valid_i <= 1'b0;
    day_count_i <= 24'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic [23:0] random_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 24'($urandom_range(0, 7304492) - 4371596);
    end else if (pick < 65) begin
      return 24'($urandom_range(0, 2000) - 80366);
    end else if (pick < 75) begin
      return 24'($urandom_range(0, 4000) - 2000);
    end else if (pick < 85) begin
      return 24'($urandom);
    end else if (pick < 92) begin
      return 24'($urandom_range(0, 400) - 4371796);
    end else begin
      return 24'($urandom_range(0, 400) + 2932696);
    end
  endfunction

  logic [23:0] directed[$] = '{
    24'sd0, -24'sd4371596, 24'sd2932896, -24'sd4371597, 24'sd2932897,
    24'h800000, 24'h7FFFFF, 24'hFFFFFF, -24'sd79366, -24'sd79367,
    -24'sd79356, -24'sd79378, -24'sd1, 24'sd11016, 24'sd11017,
    -24'sd62109, -24'sd62108, -24'sd98417, -24'sd98418, -24'sd719893,
    -24'sd719528, 24'sd10956, -24'sd25508, 24'sd1, 24'sd6
  };

  initial begin
    int burst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_count(directed[i]);
    end
    pause_sender(1);
    wait (pending == 0);
    @(posedge clk_i);
    while (sent < 1550) begin
      if (sent > 600 && hold_requests == 0) begin
        hold_requests = 1;
      end
      if (sent > 1100 && sent < 1110) begin
        pause_sender(1);
        wait (pending == 0);
        @(posedge clk_i);
      end
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (burst) send_count(random_count());
      if ($urandom_range(0, 2) != 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end
    pause_sender(1);
    wait (pending == 0);
    repeat (30) @(posedge clk_i);
    $display("sent %0d day counts, checked %0d dates", sent, checked);
    $display("covered range limits, out-of-range counts, 1752 change and leap years");
    if (fail_count == 0) begin
      $display("tb_day_number_to_civil_date_top passed");
    end else begin
      $display("tb_day_number_to_civil_date_top failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dn2cd_pkg.sv
rtl/dn2cd_front.sv
rtl/dn2cd_split.sv
rtl/dn2cd_month.sv
rtl/day_number_to_civil_date_top.sv
tb/day_number_to_civil_date_checker.sv
tb/tb_day_number_to_civil_date_top.sv
